@@ design/ultrasonic_echo_ranger_avg_top_assert.svh @@
// Assertion macros for the ultrasonic echo ranger.
`ifndef ULTRASONIC_ECHO_RANGER_AVG_TOP_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_AVG_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define UERA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define UERA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define UERA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UERA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/uera_pkg.sv @@
// Package with types, widths and constants of the ultrasonic echo ranger.
`default_nettype none

package uera_pkg;

    localparam int TRIG_W   = 10;
    localparam int TICK_W   = 20;
    localparam int MIN_W    = 8;
    localparam int SUM_W    = 28;
    localparam int CNT_W    = 8;
    localparam int Q_W      = 23;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int TICKS_PER_CM_DEF  = 58;
    localparam int FRACTION_BITS_DEF = 8;

    localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST   = TRIG_W'(10);
    localparam logic [TICK_W-1:0] RISE_TIMEOUT_RST    = TICK_W'(100000);
    localparam logic [TICK_W-1:0] FALL_TIMEOUT_RST    = TICK_W'(1000000);
    localparam logic [TICK_W-1:0] GAP_TICKS_RST       = TICK_W'(10000);
    localparam logic [MIN_W-1:0]  MIN_VALID_TICKS_RST = MIN_W'(6);

    localparam logic [2:0] REG_TRIGGER_TICKS   = 3'd0;
    localparam logic [2:0] REG_RISE_TIMEOUT    = 3'd1;
    localparam logic [2:0] REG_FALL_TIMEOUT    = 3'd2;
    localparam logic [2:0] REG_GAP_TICKS       = 3'd3;
    localparam logic [2:0] REG_MIN_VALID_TICKS = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_COUNT,
        PH_GAP
    } phase_t;

    typedef enum logic [1:0] {
        CTL_EMPTY,
        CTL_FULL,
        CTL_DIV
    } ctl_state_t;

    typedef struct packed {
        logic [TRIG_W-1:0] trigger_ticks;
        logic [TICK_W-1:0] rise_timeout;
        logic [TICK_W-1:0] fall_timeout;
        logic [TICK_W-1:0] gap_ticks;
        logic [MIN_W-1:0]  min_valid_ticks;
    } cfg_t;

    typedef struct packed {
        logic trig;
        logic busy;
        logic finish;
        logic need_div;
    } seq_stat_t;

endpackage

`default_nettype wire

@@ design/ultrasonic_echo_ranger_avg_top.sv @@
// Top level of the ultrasonic echo ranger: register port, tick sequencer, divider and output stage.
`default_nettype none
`include "ultrasonic_echo_ranger_avg_top_assert.svh"

// Each input transfer is one tick of the ranger and gives exactly one output transfer
// describing the state after that tick. An ordinary tick's result stands in the output
// register from the next cycle; a new tick is taken in the cycle in which the previous
// result is taken. The tick that closes a measurement with at least one valid sample
// stalls the input while the bit-serial divider forms one quotient bit per cycle. The
// user must write registers over the APB port only while no measurement is running;
// the block itself does not enforce this.
module ultrasonic_echo_ranger_avg_top #(
    parameter int TICKS_PER_CM  = uera_pkg::TICKS_PER_CM_DEF,
    parameter int FRACTION_BITS = uera_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [uera_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [uera_pkg::DATA_W-1:0]  pwdata,
    output logic      [uera_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         start_req,
    input  wire logic [uera_pkg::CNT_W-1:0]   sample_count,
    input  wire logic                         echo_level,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              trig_level,
    output logic                              busy_res,
    output logic                              result_valid,
    output logic      [uera_pkg::Q_W-1:0]     distance_q8,
    output logic      [uera_pkg::CNT_W-1:0]   valid_samples
);
    import uera_pkg::*;

    cfg_t                cfg_reg, cfg_next;
    ctl_state_t          ctl_state_reg, ctl_state_next;
    logic                res_reg, res_next;
    logic [2:0]          reg_index;
    logic                cfg_write;
    logic                in_accept;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [Q_W-1:0]      div_quot;
    seq_stat_t           stat;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    good_next;
    logic [CNT_W-1:0]    good_count;

    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index)
                REG_TRIGGER_TICKS:   cfg_next.trigger_ticks   = pwdata[TRIG_W-1:0];
                REG_RISE_TIMEOUT:    cfg_next.rise_timeout    = pwdata[TICK_W-1:0];
                REG_FALL_TIMEOUT:    cfg_next.fall_timeout    = pwdata[TICK_W-1:0];
                REG_GAP_TICKS:       cfg_next.gap_ticks       = pwdata[TICK_W-1:0];
                REG_MIN_VALID_TICKS: cfg_next.min_valid_ticks = pwdata[MIN_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_TRIGGER_TICKS:   prdata = DATA_W'(cfg_reg.trigger_ticks);
            REG_RISE_TIMEOUT:    prdata = DATA_W'(cfg_reg.rise_timeout);
            REG_FALL_TIMEOUT:    prdata = DATA_W'(cfg_reg.fall_timeout);
            REG_GAP_TICKS:       prdata = DATA_W'(cfg_reg.gap_ticks);
            REG_MIN_VALID_TICKS: prdata = DATA_W'(cfg_reg.min_valid_ticks);
            default:             prdata = '0;
        endcase
    end

    uera_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_accept),
        .start_req    (start_req),
        .sample_count (sample_count),
        .echo_level   (echo_level),
        .cfg          (cfg_reg),
        .stat         (stat),
        .sum_next     (sum_next),
        .good_next    (good_next),
        .good_count   (good_count)
    );

    uera_div #(
        .TICKS_PER_CM  (TICKS_PER_CM),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .sum_in  (sum_next),
        .good_in (good_next),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb
    begin
        ctl_state_next = ctl_state_reg;
        case (ctl_state_reg)
            CTL_EMPTY:
            begin
                if (in_valid)
                begin
                    ctl_state_next = stat.need_div ? CTL_DIV : CTL_FULL;
                end
            end
            CTL_FULL:
            begin
                if (!out_stall)
                begin
                    if (in_valid)
                    begin
                        ctl_state_next = stat.need_div ? CTL_DIV : CTL_FULL;
                    end
                    else
                    begin
                        ctl_state_next = CTL_EMPTY;
                    end
                end
            end
            CTL_DIV:
            begin
                if (div_done)
                begin
                    ctl_state_next = CTL_FULL;
                end
            end
            default:
            begin
                ctl_state_next = CTL_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        case (ctl_state_reg)
            CTL_EMPTY:
            begin
                in_stall  = 1'b0;
                out_valid = 1'b0;
            end
            CTL_FULL:
            begin
                in_stall  = out_stall;
                out_valid = 1'b1;
            end
            CTL_DIV:
            begin
                in_stall  = 1'b1;
                out_valid = 1'b0;
            end
            default:
            begin
                in_stall  = 1'b1;
                out_valid = 1'b0;
            end
        endcase
        in_accept = in_valid & ~in_stall;
        div_start = in_accept & stat.need_div;
        res_next  = in_accept ? stat.finish : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks   <= TRIGGER_TICKS_RST;
            cfg_reg.rise_timeout    <= RISE_TIMEOUT_RST;
            cfg_reg.fall_timeout    <= FALL_TIMEOUT_RST;
            cfg_reg.gap_ticks       <= GAP_TICKS_RST;
            cfg_reg.min_valid_ticks <= MIN_VALID_TICKS_RST;
            ctl_state_reg           <= CTL_EMPTY;
            res_reg                 <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            ctl_state_reg <= ctl_state_next;
            res_reg       <= res_next;
        end
    end

    assign trig_level    = stat.trig;
    assign busy_res      = stat.busy;
    assign result_valid  = res_reg;
    assign distance_q8   = (res_reg && (good_count != '0)) ? div_quot : '0;
    assign valid_samples = res_reg ? good_count : '0;

    `UERA_ASSERT_IMP(a_distance_needs_samples, clk, rst_n, out_valid && (distance_q8 != '0), valid_samples != '0)
    `UERA_ASSERT_IMP(a_idle_payload_zero, clk, rst_n, out_valid && !result_valid, distance_q8 == '0 && valid_samples == '0)
    `UERA_ASSERT_NXT(a_divide_follows, clk, rst_n, div_start, ctl_state_reg == CTL_DIV && div_busy)
    `UERA_ASSERT_IMP(a_trigger_when_busy, clk, rst_n, out_valid && trig_level, busy_res)

endmodule

`default_nettype wire

@@ design/uera_seq.sv @@
// Tick sequencer: trigger, echo wait, echo count, gap and accumulation of valid samples.
`default_nettype none

module uera_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic                        start_req,
    input  wire logic [uera_pkg::CNT_W-1:0]  sample_count,
    input  wire logic                        echo_level,
    input  wire uera_pkg::cfg_t              cfg,
    output uera_pkg::seq_stat_t              stat,
    output logic      [uera_pkg::SUM_W-1:0]  sum_next,
    output logic      [uera_pkg::CNT_W-1:0]  good_next,
    output logic      [uera_pkg::CNT_W-1:0]  good_count
);
    import uera_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   pc_reg, pc_next;
    logic [TICK_W-1:0]   echo_reg, echo_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    good_reg;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic                done_now;
    logic                zero_start;
    logic                sample_end;
    logic                gap_go;
    logic                round_end;

    always_comb
    begin
        phase_next = phase_reg;
        pc_next    = pc_reg;
        echo_next  = echo_reg;
        sum_next   = sum_reg;
        good_next  = good_reg;
        left_next  = left_reg;
        done_now   = 1'b0;
        zero_start = 1'b0;
        sample_end = 1'b0;
        gap_go     = 1'b0;
        round_end  = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    sum_next  = '0;
                    good_next = '0;
                    echo_next = '0;
                    if (sample_count == '0)
                    begin
                        left_next  = '0;
                        zero_start = 1'b1;
                    end
                    else
                    begin
                        left_next  = sample_count;
                        phase_next = PH_TRIG;
                        pc_next    = TICK_W'(1);
                    end
                end
            end
            PH_TRIG:
            begin
                if (pc_reg >= TICK_W'(cfg.trigger_ticks))
                begin
                    phase_next = PH_RISE;
                    pc_next    = '0;
                end
                else
                begin
                    pc_next = pc_reg + TICK_W'(1);
                end
            end
            PH_RISE:
            begin
                if (echo_level)
                begin
                    phase_next = PH_COUNT;
                    echo_next  = TICK_W'(1);
                    if (TICK_W'(1) >= cfg.fall_timeout)
                    begin
                        sample_end = 1'b1;
                    end
                end
                else if (({1'b0, pc_reg} + (TICK_W+1)'(1)) > {1'b0, cfg.rise_timeout})
                begin
                    echo_next = '0;
                    gap_go    = 1'b1;
                end
                else
                begin
                    pc_next = pc_reg + TICK_W'(1);
                end
            end
            PH_COUNT:
            begin
                if (!echo_level)
                begin
                    sample_end = 1'b1;
                end
                else
                begin
                    echo_next = echo_reg + TICK_W'(1);
                    if (echo_next >= cfg.fall_timeout)
                    begin
                        sample_end = 1'b1;
                    end
                end
            end
            PH_GAP:
            begin
                pc_next = pc_reg + TICK_W'(1);
                if (pc_next >= cfg.gap_ticks)
                begin
                    round_end = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (sample_end)
        begin
            if (echo_next >= TICK_W'(cfg.min_valid_ticks))
            begin
                sum_next  = sum_reg + SUM_W'(echo_next);
                good_next = good_reg + CNT_W'(1);
            end
            gap_go = 1'b1;
        end

        if (gap_go)
        begin
            pc_next = '0;
            if (cfg.gap_ticks == '0)
            begin
                round_end = 1'b1;
            end
            else
            begin
                phase_next = PH_GAP;
            end
        end

        if (round_end)
        begin
            left_next = left_reg - CNT_W'(1);
            if (left_next == '0)
            begin
                phase_next = PH_IDLE;
                pc_next    = '0;
                done_now   = 1'b1;
            end
            else
            begin
                phase_next = PH_TRIG;
                pc_next    = TICK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pc_reg    <= '0;
            echo_reg  <= '0;
            sum_reg   <= '0;
            good_reg  <= '0;
            left_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            echo_reg  <= echo_next;
            sum_reg   <= sum_next;
            good_reg  <= good_next;
            left_reg  <= left_next;
        end
    end

    always_comb
    begin
        stat.trig     = (phase_reg == PH_TRIG);
        stat.busy     = (phase_reg != PH_IDLE);
        stat.finish   = done_now | zero_start;
        stat.need_div = done_now & (good_next != '0);
        good_count    = good_reg;
    end

endmodule

`default_nettype wire

@@ design/uera_div.sv @@
// Bit-serial restoring divider for the averaged distance, one quotient bit per cycle.
`default_nettype none

module uera_div #(
    parameter int TICKS_PER_CM  = uera_pkg::TICKS_PER_CM_DEF,
    parameter int FRACTION_BITS = uera_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [uera_pkg::SUM_W-1:0]  sum_in,
    input  wire logic [uera_pkg::CNT_W-1:0]  good_in,
    output logic                             busy,
    output logic                             done,
    output logic      [uera_pkg::Q_W-1:0]    quot
);
    import uera_pkg::*;

    localparam int NUM_W  = SUM_W + FRACTION_BITS;
    localparam int DEN_W  = $clog2(TICKS_PER_CM + 1) + CNT_W;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0]    quot_reg, quot_next;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              fits;

    always_comb
    begin
        shifted   = {rem_reg, num_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        fits      = (shifted >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(NUM_W);
            num_next  = NUM_W'(sum_in) << FRACTION_BITS;
            den_next  = DEN_W'(TICKS_PER_CM) * DEN_W'(good_in);
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            num_next  = num_reg << 1;
            rem_next  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quot_next = {quot_reg[Q_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire
